// ===== hdl/dskp_pkg.sv =====
package dskp_pkg;

    localparam int LEN_BYTES_MAX = 8;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_OCTET    = 8'h04;
    localparam logic [7:0] LEN_LONG_BIT = 8'h80;
    localparam logic [7:0] LEN_CNT_MASK = 8'h7f;

    typedef enum logic [3:0] {
        PH_SEQ_TAG  = 4'd0,
        PH_SEQ_LEN  = 4'd1,
        PH_SEQ_LENX = 4'd2,
        PH_TAG      = 4'd3,
        PH_LEN      = 4'd4,
        PH_LENX     = 4'd5,
        PH_CONTENT  = 4'd6,
        PH_DONE     = 4'd7,
        PH_SINK     = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_SEQ     = 3'd1,
        ST_TRUNC      = 3'd2,
        ST_BAD_LEN    = 3'd3,
        ST_MISMATCH   = 3'd4,
        ST_NO_OCTET   = 3'd5,
        ST_OCT_TRUNC  = 3'd6,
        ST_INCOMPLETE = 3'd7
    } status_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] out_byte;
        logic       done_res;
        logic       byte_valid;
        logic       part;
    } res_t;

endpackage

// ===== hdl/dskp_front.sv =====
module dskp_front (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_accept,
    input  logic [7:0]   in_byte,
    input  logic         last_byte,
    output logic         res_push,
    output dskp_pkg::res_t res_data
);
    import dskp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [63:0] accum_reg, accum_next;
    logic [3:0]  lbl_reg, lbl_next;
    logic [63:0] seq_len_reg, seq_len_next;
    logic [63:0] remaining_reg, remaining_next;
    logic        over_reg, over_next;
    logic        seq_max_reg, seq_max_next;
    logic [63:0] content_reg, content_next;
    status_t     ferr_reg, ferr_next;
    logic [1:0]  nonempty_reg, nonempty_next;
    logic        oidx_reg, oidx_next;
    logic        hdr_reg, hdr_next;

    logic [63:0] accum_shift;
    logic [63:0] oct_len;
    logic [6:0]  cnt;
    logic        cnt_bad;
    logic [3:0]  lbl_dec;
    logic        valid;
    status_t     fin_status;

    assign accum_shift = {accum_reg[55:0], in_byte};
    assign cnt         = in_byte[6:0] & LEN_CNT_MASK[6:0];
    assign cnt_bad     = (cnt == 7'd0) || ({25'd0, cnt} > 32'(LEN_BYTES_MAX));
    assign lbl_dec     = (lbl_reg != 4'd0) ? lbl_reg - 4'd1 : 4'd0;
    assign oct_len     = (phase_reg == PH_LEN) ? {56'd0, in_byte} : accum_shift;

    always_comb begin
        phase_next     = phase_reg;
        accum_next     = accum_reg;
        lbl_next       = lbl_reg;
        seq_len_next   = seq_len_reg;
        remaining_next = remaining_reg;
        over_next      = over_reg;
        seq_max_next   = seq_max_reg;
        content_next   = content_reg;
        ferr_next      = ferr_reg;
        nonempty_next  = nonempty_reg;
        oidx_next      = oidx_reg;
        hdr_next       = hdr_reg;
        valid          = 1'b0;

        if (hdr_reg) begin
            if (remaining_reg == 64'd0) begin
                over_next = over_reg | ~seq_max_reg;
            end else begin
                remaining_next = remaining_reg - 64'd1;
            end
            if (phase_reg != PH_SINK && remaining_reg == 64'd0) begin
                phase_next = PH_SINK;
            end else if (phase_reg != PH_SINK) begin
                case (phase_reg)
                    PH_TAG: begin
                        if (in_byte != TAG_OCTET) begin
                            ferr_next  = ST_NO_OCTET;
                            phase_next = PH_SINK;
                        end else begin
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN, PH_LENX: begin
                        if (phase_reg == PH_LEN && (in_byte & LEN_LONG_BIT) != 8'd0) begin
                            if (cnt_bad || {57'd0, cnt} >= remaining_reg) begin
                                ferr_next  = ST_BAD_LEN;
                                phase_next = PH_SINK;
                            end else begin
                                lbl_next   = cnt[3:0];
                                accum_next = 64'd0;
                                phase_next = PH_LENX;
                            end
                        end else begin
                            if (phase_reg == PH_LENX) begin
                                accum_next = accum_shift;
                                lbl_next   = lbl_dec;
                            end
                            if (phase_reg == PH_LEN || lbl_dec == 4'd0) begin
                                if (oct_len >= remaining_reg) begin
                                    ferr_next  = ST_OCT_TRUNC;
                                    phase_next = PH_SINK;
                                end else if (oct_len == 64'd0) begin
                                    if (oidx_reg == 1'b0) begin
                                        oidx_next  = 1'b1;
                                        phase_next = PH_TAG;
                                    end else begin
                                        phase_next = PH_DONE;
                                    end
                                end else begin
                                    content_next = oct_len;
                                    phase_next   = PH_CONTENT;
                                end
                            end
                        end
                    end
                    PH_CONTENT: begin
                        valid = 1'b1;
                        if (content_reg != 64'd0) begin
                            content_next = content_reg - 64'd1;
                        end
                        if (content_reg <= 64'd1) begin
                            nonempty_next[oidx_reg] = 1'b1;
                            if (oidx_reg == 1'b0) begin
                                oidx_next  = 1'b1;
                                phase_next = PH_TAG;
                            end else begin
                                phase_next = PH_DONE;
                            end
                        end
                    end
                    PH_DONE: begin
                        ferr_next  = ST_INCOMPLETE;
                        phase_next = PH_SINK;
                    end
                    default: begin
                        phase_next = PH_SINK;
                    end
                endcase
            end
        end else begin
            case (phase_reg)
                PH_SEQ_TAG: begin
                    if (in_byte != TAG_SEQUENCE) begin
                        ferr_next  = ST_NO_SEQ;
                        phase_next = PH_SINK;
                    end else begin
                        phase_next = PH_SEQ_LEN;
                    end
                end
                PH_SEQ_LEN: begin
                    if ((in_byte & LEN_LONG_BIT) == 8'd0) begin
                        seq_len_next   = {56'd0, in_byte};
                        remaining_next = {56'd0, in_byte};
                        seq_max_next   = 1'b0;
                        over_next      = 1'b0;
                        hdr_next       = 1'b1;
                        phase_next     = PH_TAG;
                    end else if (cnt_bad) begin
                        ferr_next  = ST_BAD_LEN;
                        phase_next = PH_SINK;
                    end else begin
                        lbl_next   = cnt[3:0];
                        accum_next = 64'd0;
                        phase_next = PH_SEQ_LENX;
                    end
                end
                PH_SEQ_LENX: begin
                    accum_next = accum_shift;
                    lbl_next   = lbl_dec;
                    if (lbl_dec == 4'd0) begin
                        seq_len_next   = accum_shift;
                        remaining_next = accum_shift;
                        seq_max_next   = &accum_shift;
                        over_next      = 1'b0;
                        hdr_next       = 1'b1;
                        phase_next     = PH_TAG;
                    end
                end
                default: begin
                    phase_next = PH_SINK;
                end
            endcase
        end
    end

    always_comb begin
        if (!hdr_next) begin
            if (ferr_next != ST_OK) begin
                fin_status = ferr_next;
            end else if (phase_next == PH_SEQ_LEN) begin
                fin_status = ST_TRUNC;
            end else begin
                fin_status = ST_BAD_LEN;
            end
        end else if (over_next || remaining_next != 64'd0) begin
            fin_status = ST_MISMATCH;
        end else if (ferr_next != ST_OK) begin
            fin_status = ferr_next;
        end else begin
            case (phase_next)
                PH_TAG:     fin_status = ST_NO_OCTET;
                PH_LEN:     fin_status = ST_TRUNC;
                PH_LENX:    fin_status = ST_BAD_LEN;
                PH_CONTENT: fin_status = ST_OCT_TRUNC;
                PH_DONE:    fin_status = (nonempty_next == 2'b11) ? ST_OK : ST_INCOMPLETE;
                default:    fin_status = ST_INCOMPLETE;
            endcase
        end
    end

    assign res_push            = in_accept && (valid || last_byte);
    assign res_data.out_byte   = valid ? in_byte : 8'd0;
    assign res_data.part       = valid ? oidx_reg : 1'b0;
    assign res_data.byte_valid = valid;
    assign res_data.done_res   = last_byte;
    assign res_data.status     = last_byte ? fin_status : ST_OK;

    // the final byte of a message returns everything to the reset state
    always_ff @(posedge aclk) begin
        if (!aresetn || (in_accept && last_byte)) begin
            phase_reg     <= PH_SEQ_TAG;
            accum_reg     <= 64'd0;
            lbl_reg       <= 4'd0;
            seq_len_reg   <= 64'd0;
            remaining_reg <= 64'd0;
            over_reg      <= 1'b0;
            seq_max_reg   <= 1'b0;
            content_reg   <= 64'd0;
            ferr_reg      <= ST_OK;
            nonempty_reg  <= 2'b00;
            oidx_reg      <= 1'b0;
            hdr_reg       <= 1'b0;
        end else if (in_accept) begin
            phase_reg     <= phase_next;
            accum_reg     <= accum_next;
            lbl_reg       <= lbl_next;
            seq_len_reg   <= seq_len_next;
            remaining_reg <= remaining_next;
            over_reg      <= over_next;
            seq_max_reg   <= seq_max_next;
            content_reg   <= content_next;
            ferr_reg      <= ferr_next;
            nonempty_reg  <= nonempty_next;
            oidx_reg      <= oidx_next;
            hdr_reg       <= hdr_next;
        end
    end

endmodule

// ===== hdl/dskp_queue.sv =====
module dskp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  dskp_pkg::res_t push_data,
    input  logic           pop,
    output dskp_pkg::res_t pop_data,
    output logic           not_empty,
    output logic           not_full
);
    import dskp_pkg::*;

    res_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign not_empty = (count_reg != QCNT_W'(0));
    assign not_full  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue pop while empty");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == QCNT_W'(0) || count_reg == QCNT_W'(QUEUE_DEPTH))
        |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== hdl/dskp_back.sv =====
module dskp_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_not_empty,
    input  dskp_pkg::res_t q_data,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output dskp_pkg::res_t out_data
);
    import dskp_pkg::*;

    logic valid_reg, valid_next;
    res_t data_reg;

    assign q_pop     = q_not_empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (q_pop) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= q_data;
        end
    end

endmodule

// ===== hdl/der_signed_key_extension_parser_core.sv =====
// DER signed-key extension parser.
// s_ channel: one message byte per transaction, s_tlast on the final byte.
// m_ channel: one transaction per content byte of either OCTET STRING
// (m_tuser[1] set, m_tuser[0] tells public key or signature), and one for
// the final input byte (m_tlast set, status in m_tdata[10:8]). A content
// byte that is also final yields a single transaction carrying both.
// Content must be dropped by the receiver unless the final status is ok.
// Throughput: one byte per cycle while the queue has room; the parser updates
// its phase and 64-bit counters once for each byte it takes.
// Each result is written into the 4-entry queue at the edge that accepts its
// byte; the output register loads it from the queue once that register is
// empty or its current result is taken by m_tready.
// Reset: aresetn low for one cycle empties the queue and output register
// and returns the parser to the sequence tag; the final byte of a message
// does the same for the parser.
// When m_tready is held low the queue fills and s_tready drops; no
// transaction is lost or repeated.
module der_signed_key_extension_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] status, rest zero
    output logic [1:0]  m_tuser,   // [0] part, [1] byte_valid
    output logic        m_tlast
);
    import dskp_pkg::*;

    logic s_accept;
    logic push, pop, q_not_empty, q_not_full;
    res_t push_data, q_data, out_data;

    assign s_tready = q_not_full;
    assign s_accept = s_tvalid && q_not_full;

    dskp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_accept),
        .in_byte   (s_tdata),
        .last_byte (s_tlast),
        .res_push  (push),
        .res_data  (push_data)
    );

    dskp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (q_data),
        .not_empty (q_not_empty),
        .not_full  (q_not_full)
    );

    dskp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .q_pop       (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (out_data)
    );

    assign m_tdata = {5'd0, out_data.status, out_data.out_byte};
    assign m_tuser = {out_data.byte_valid, out_data.part};
    assign m_tlast = out_data.done_res;

endmodule
